[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bstcr_pkg.sv]
// shared types and constants for the bitmap set/test/clear-range block
package bstcr_pkg;

   localparam int INDEX_BITS  = 10;
   localparam int ACTIVE_BITS = 11;
   localparam int DIV_SHIFT   = 20;

   typedef logic [1:0]             opcode_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [ACTIVE_BITS-1:0] active_type;

   localparam opcode_type OP_TEST  = 2'd0;
   localparam opcode_type OP_SET   = 2'd1;
   localparam opcode_type OP_CLEAR = 2'd2;

   localparam active_type ACTIVE_RESET = 11'd1024;

endpackage

[hdl/bstcr_ram.sv]
// generic single-port-write ram with registered read
module bstcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bitmap_set_test_clear_range.sv]
// bitmap with test, set and clear-range operations over a word ram
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    opcode, bit_index, range_end
//   rsp      out        rsp_valid/stall    bit_value, status
//   csr      in         csr_valid/ready    active_bits
//
// one item at a time; test and set step through locate, read, modify and done, clear range
// repeats read and modify per word spanned, and an out-of-range index or reversed range
// goes to done; reset clears the map at once through per-word valid bits, no sweep
// req_stall is high from acceptance until the result enters the output register
// a stalled result holds in the output register while the next item is accepted
module bitmap_set_test_clear_range #(
   parameter int NUM_BITS  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bstcr_pkg::opcode_type   req_opcode,
   input  bstcr_pkg::index_type    req_bit_index,
   input  bstcr_pkg::index_type    req_range_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_bit_value,
   output logic                    rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bstcr_pkg::active_type   csr_active_bits
);

   localparam int STORE_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int BW          = $clog2(WORD_BITS);
   localparam int SW          = $clog2(NUM_BITS + 1);
   localparam int CW          = (SW > bstcr_pkg::ACTIVE_BITS) ? SW : bstcr_pkg::ACTIVE_BITS;
   localparam int PW          = bstcr_pkg::INDEX_BITS + bstcr_pkg::DIV_SHIFT + 1;
   localparam int RECIP       = ((1 << bstcr_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOCATE = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_MODIFY = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [AW-1:0]        addr_type;
   typedef logic [BW-1:0]        bitpos_type;
   typedef logic [CW-1:0]        size_type;

   function automatic addr_type word_of(input bstcr_pkg::index_type x);
      logic [PW-1:0] prod;
      prod = PW'(x) * PW'(RECIP);
      return AW'(prod[bstcr_pkg::DIV_SHIFT +: bstcr_pkg::INDEX_BITS]);
   endfunction

   function automatic bitpos_type bit_of(input bstcr_pkg::index_type x, input addr_type w);
      bstcr_pkg::index_type base;
      base = bstcr_pkg::INDEX_BITS'(w) * bstcr_pkg::INDEX_BITS'(WORD_BITS);
      return BW'(x - base);
   endfunction

   logic [2:0]            state_ff, state_in;
   bstcr_pkg::active_type active_bits_ff, active_bits_in;
   logic [STORE_WORDS-1:0] word_valid_ff, word_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_bit_value_ff, rsp_bit_value_in;
   logic                  rsp_status_ff, rsp_status_in;
   bstcr_pkg::opcode_type op_ff, op_in;
   bstcr_pkg::index_type  first_ff, first_in;
   bstcr_pkg::index_type  last_ff, last_in;
   addr_type              first_word_ff, first_word_in;
   addr_type              last_word_ff, last_word_in;
   addr_type              word_ptr_ff, word_ptr_in;
   bitpos_type            start_bit_ff, start_bit_in;
   bitpos_type            end_bit_ff, end_bit_in;
   logic                  res_value_ff, res_value_in;
   logic                  res_status_ff, res_status_in;

   logic                  req_accept;
   size_type              active_ext;
   size_type              size;
   size_type              idx_ext;
   size_type              end_ext;
   size_type              last_clip;
   logic                  op_bad;
   logic                  idx_err;
   logic                  reversed;
   word_type              old_word;
   word_type              set_mask;
   word_type              clear_mask;
   bitpos_type            lo_bit;
   bitpos_type            hi_bit;
   logic                  ram_wr_en;
   word_type              ram_wr_data;
   logic                  ram_rd_en;
   word_type              ram_rd_data;
   logic                  out_load;

   bstcr_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (word_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // request checks
   always_comb begin
      active_ext = CW'(active_bits_ff);
      size       = (active_ext > CW'(NUM_BITS)) ? CW'(NUM_BITS) : active_ext;
      idx_ext    = CW'(req_bit_index);
      end_ext    = CW'(req_range_end);
      last_clip  = (end_ext >= size) ? (size - CW'(1)) : end_ext;
      op_bad     = (req_opcode != bstcr_pkg::OP_TEST) && (req_opcode != bstcr_pkg::OP_SET) &&
                   (req_opcode != bstcr_pkg::OP_CLEAR);
      idx_err    = op_bad || (idx_ext >= size);
      reversed   = (last_clip < idx_ext);
   end

   // shared mask unit
   always_comb begin
      old_word   = word_valid_ff[word_ptr_ff] ? ram_rd_data : '0;
      lo_bit     = (word_ptr_ff == first_word_ff) ? start_bit_ff : '0;
      hi_bit     = (word_ptr_ff == last_word_ff) ? end_bit_ff : BW'(WORD_BITS - 1);
      set_mask   = word_type'(1) << start_bit_ff;
      clear_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                   ({WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - hi_bit));
   end

   always_comb begin
      state_in         = state_ff;
      active_bits_in   = active_bits_ff;
      word_valid_in    = word_valid_ff;
      op_in            = op_ff;
      first_in         = first_ff;
      last_in          = last_ff;
      first_word_in    = first_word_ff;
      last_word_in     = last_word_ff;
      word_ptr_in      = word_ptr_ff;
      start_bit_in     = start_bit_ff;
      end_bit_in       = end_bit_ff;
      res_value_in     = res_value_ff;
      res_status_in    = res_status_ff;
      ram_wr_en        = 1'b0;
      ram_wr_data      = old_word;
      ram_rd_en        = 1'b0;
      out_load         = 1'b0;

      if (csr_valid && csr_ready) begin
         active_bits_in = csr_active_bits;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in         = req_opcode;
               first_in      = req_bit_index;
               last_in       = bstcr_pkg::INDEX_BITS'(last_clip);
               res_value_in  = 1'b0;
               res_status_in = idx_err;
               if (idx_err || ((req_opcode == bstcr_pkg::OP_CLEAR) && reversed)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LOCATE;
               end
            end
         end
         ST_LOCATE: begin
            first_word_in = word_of(first_ff);
            last_word_in  = word_of(last_ff);
            word_ptr_in   = word_of(first_ff);
            state_in      = ST_READ;
         end
         ST_READ: begin
            ram_rd_en    = 1'b1;
            start_bit_in = bit_of(first_ff, first_word_ff);
            end_bit_in   = bit_of(last_ff, last_word_ff);
            state_in     = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == bstcr_pkg::OP_TEST) begin
               res_value_in = old_word[start_bit_ff];
               state_in     = ST_DONE;
            end else begin
               ram_wr_en                  = 1'b1;
               word_valid_in[word_ptr_ff] = 1'b1;
               if (op_ff == bstcr_pkg::OP_SET) begin
                  ram_wr_data = old_word | set_mask;
                  state_in    = ST_DONE;
               end else begin
                  ram_wr_data = old_word & ~clear_mask;
                  if (word_ptr_ff == last_word_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     word_ptr_in = word_ptr_ff + AW'(1);
                     state_in    = ST_READ;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in     = (rsp_valid_ff && rsp_stall) || out_load;
      rsp_bit_value_in = out_load ? res_value_ff : rsp_bit_value_ff;
      rsp_status_in    = out_load ? res_status_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_bits_ff <= bstcr_pkg::ACTIVE_RESET;
         word_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_bits_ff <= active_bits_in;
         word_valid_ff  <= word_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      first_ff         <= first_in;
      last_ff          <= last_in;
      first_word_ff    <= first_word_in;
      last_word_ff     <= last_word_in;
      word_ptr_ff      <= word_ptr_in;
      start_bit_ff     <= start_bit_in;
      end_bit_ff       <= end_bit_in;
      res_value_ff     <= res_value_in;
      res_status_ff    <= res_status_in;
      rsp_bit_value_ff <= rsp_bit_value_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bit_value = rsp_bit_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[hdl/bstcr_checker.sv]
// port-level checks for the bitmap block, bound to the top level
`include "assert_macros.svh"

module bstcr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_bit_value,
   input logic rsp_status
);

   // one item at a time
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall, "request side not busy after item")

   // an error never reports a bit
   `ASSERT_CLK_RST(a_error_no_value, clock, reset, (rsp_valid && rsp_status) |-> !rsp_bit_value, "bit value set on error")

   `ASSERT_CLK_RST(a_rsp_valid_holds, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped while stalled")

   `ASSERT_CLK_RST(a_rsp_payload_holds, clock, reset, (rsp_valid && rsp_stall) |=> ($stable(rsp_bit_value) && $stable(rsp_status)), "result changed while stalled")

endmodule

bind bitmap_set_test_clear_range bstcr_checker u_checker (.*);

[bench/bitmap_set_test_clear_range_tb.sv]
// testbench for the bitmap block: directed table, then random items against a predictor
`timescale 1ns / 1ps

module bitmap_set_test_clear_range_tb;

   localparam bstcr_pkg::opcode_type OP_UNUSED = 2'd3;
   localparam bit ST_DONE  = 1'b0;
   localparam bit ST_RANGE = 1'b1;
   localparam int NUM_FLAGS = 1024;
   localparam int DIR_ROWS  = 27;
   localparam int PHASES    = 8;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      bit value;
      bit status;
   } flag_result_type;

   typedef struct packed {
      bit                     do_csr;
      bstcr_pkg::active_type  csr_value;
      bstcr_pkg::opcode_type  op;
      bstcr_pkg::index_type   idx;
      bstcr_pkg::index_type   last;
      bit                     typed;
      flag_result_type        exp;
   } dir_row_type;

   localparam flag_result_type DONE  = '{1'b0, ST_DONE};
   localparam flag_result_type RANGE = '{1'b0, ST_RANGE};
   localparam flag_result_type NONE  = '{1'b0, 1'b0};

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd0,    10'd0,    1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd1023, 10'd1023, 1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_SET,   10'd0,    10'd1023, 1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_SET,   10'd1023, 10'd0,    1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_SET,   10'd31,   10'd0,    1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_SET,   10'd32,   10'd0,    1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd0,    10'd0,    1'b0, NONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd31,   10'd0,    1'b0, NONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, OP_UNUSED,           10'd1023, 10'd1023, 1'b1, RANGE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_CLEAR, 10'd1,    10'd1023, 1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd0,    10'd0,    1'b0, NONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd1023, 10'd0,    1'b0, NONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_CLEAR, 10'd10,   10'd5,    1'b1, DONE},
      '{1'b1, 11'd100,                 bstcr_pkg::OP_SET,   10'd99,   10'd0,    1'b1, DONE},
      '{1'b0, 11'd100,                 bstcr_pkg::OP_TEST,  10'd100,  10'd0,    1'b1, RANGE},
      '{1'b0, 11'd100,                 bstcr_pkg::OP_CLEAR, 10'd100,  10'd200,  1'b1, RANGE},
      '{1'b0, 11'd100,                 bstcr_pkg::OP_CLEAR, 10'd0,    10'd1023, 1'b1, DONE},
      '{1'b0, 11'd100,                 bstcr_pkg::OP_TEST,  10'd99,   10'd0,    1'b0, NONE},
      '{1'b1, 11'd0,                   bstcr_pkg::OP_TEST,  10'd0,    10'd0,    1'b1, RANGE},
      '{1'b0, 11'd0,                   bstcr_pkg::OP_SET,   10'd0,    10'd0,    1'b1, RANGE},
      '{1'b1, 11'd1,                   bstcr_pkg::OP_SET,   10'd0,    10'd0,    1'b1, DONE},
      '{1'b0, 11'd1,                   bstcr_pkg::OP_TEST,  10'd0,    10'd0,    1'b0, NONE},
      '{1'b0, 11'd1,                   bstcr_pkg::OP_TEST,  10'd1,    10'd0,    1'b1, RANGE},
      '{1'b1, 11'd2047,                bstcr_pkg::OP_SET,   10'd1023, 10'd0,    1'b1, DONE},
      '{1'b0, 11'd2047,                bstcr_pkg::OP_TEST,  10'd1023, 10'd0,    1'b0, NONE},
      '{1'b1, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_CLEAR, 10'd0,    10'd1023, 1'b1, DONE},
      '{1'b0, bstcr_pkg::ACTIVE_RESET, bstcr_pkg::OP_TEST,  10'd1023, 10'd0,    1'b0, NONE}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   bstcr_pkg::opcode_type req_opcode;
   bstcr_pkg::index_type  req_bit_index;
   bstcr_pkg::index_type  req_range_end;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_bit_value;
   logic                  rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   bstcr_pkg::active_type csr_active_bits;

   bit [NUM_FLAGS-1:0]    flag_map;
   bstcr_pkg::active_type size_reg;
   flag_result_type       pending_results [$];
   int unsigned           err_count;
   int                    req_idle_pct;
   int                    rsp_stall_pct;

   bitmap_set_test_clear_range uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_bit_index   (req_bit_index),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_active_bits (csr_active_bits)
   );

   always #6 clock = ~clock;

   function automatic int unsigned flags_in_use();
      return (size_reg > NUM_FLAGS) ? NUM_FLAGS : 32'(size_reg);
   endfunction

   function automatic flag_result_type bitmap_apply(bstcr_pkg::opcode_type op,
                                                    bstcr_pkg::index_type idx,
                                                    bstcr_pkg::index_type last);
      flag_result_type res;
      int unsigned     lim;
      int              stop;
      res = '{1'b0, ST_DONE};
      lim = flags_in_use();
      if (op == OP_UNUSED || idx >= lim) begin
         res.status = ST_RANGE;
      end else begin
         case (op)
            bstcr_pkg::OP_TEST: begin
               res.value = flag_map[idx];
            end
            bstcr_pkg::OP_SET: begin
               flag_map[idx] = 1'b1;
            end
            default: begin
               stop = int'((last >= lim) ? lim - 1 : 32'(last));
               for (int i = int'(idx); i <= stop; i++)
                  flag_map[i] = 1'b0;
            end
         endcase
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      err_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_size(input bstcr_pkg::active_type value);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_active_bits <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
   endtask

   task automatic send_req(input bstcr_pkg::opcode_type op, input bstcr_pkg::index_type idx,
                           input bstcr_pkg::index_type last, input bit typed,
                           input flag_result_type typed_res);
      flag_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_bit_index <= idx;
      req_range_end <= last;
      do @(posedge clock); while (req_stall);
      predicted = bitmap_apply(op, idx, last);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      flag_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_bit_value !== want.value)
               report_mismatch($sformatf("bit_value %b, expected %b", rsp_bit_value, want.value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %b, expected %b", rsp_status, want.status));
         end
      end
   end

   initial begin
      #12_000_000;
      $display("bitmap_set_test_clear_range test failed");
      $finish;
   end

   initial begin
      bstcr_pkg::opcode_type op;
      bstcr_pkg::index_type  idx;
      bstcr_pkg::index_type  last;
      int unsigned           lim;
      int unsigned           roll;
      bstcr_pkg::active_type new_size;
      err_count       = 0;
      flag_map        = '0;
      size_reg        = bstcr_pkg::ACTIVE_RESET;
      req_idle_pct    = 0;
      rsp_stall_pct   = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= bstcr_pkg::OP_TEST;
      req_bit_index   <= '0;
      req_range_end   <= '0;
      csr_valid       <= 1'b0;
      csr_active_bits <= bstcr_pkg::ACTIVE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_rows[r].do_csr)
            write_size(dir_rows[r].csr_value);
         send_req(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].last, dir_rows[r].typed,
                  dir_rows[r].exp);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: new_size = bstcr_pkg::ACTIVE_RESET;
            1: new_size = bstcr_pkg::active_type'($urandom_range(1023, 33));
            2: new_size = 11'd2047;
            3: new_size = bstcr_pkg::active_type'($urandom_range(40, 1));
            4: new_size = bstcr_pkg::active_type'($urandom_range(2046, 1025));
            5: new_size = 11'd1;
            6: new_size = bstcr_pkg::active_type'($urandom_range(2047, 0));
            default: new_size = bstcr_pkg::ACTIVE_RESET;
         endcase
         write_size(new_size);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         lim = flags_in_use();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until the block has emptied, once
            if (phase == 3 && n == PHASE_ITEMS / 2)
               wait_drained();
            roll = $urandom_range(99);
            if (roll < 35)
               op = bstcr_pkg::OP_TEST;
            else if (roll < 70)
               op = bstcr_pkg::OP_SET;
            else if (roll < 92)
               op = bstcr_pkg::OP_CLEAR;
            else
               op = OP_UNUSED;
            roll = $urandom_range(99);
            if (lim == 0 || roll < 15)
               idx = bstcr_pkg::index_type'($urandom_range(1023));
            else if (roll < 25)
               idx = bstcr_pkg::index_type'(lim - 1);
            else
               idx = bstcr_pkg::index_type'($urandom_range(lim - 1));
            roll = $urandom_range(99);
            if (op != bstcr_pkg::OP_CLEAR || roll >= 80)
               last = bstcr_pkg::index_type'($urandom_range(1023));
            else if (roll < 60)
               last = bstcr_pkg::index_type'(32'(idx) + $urandom_range(40));
            else
               last = 10'd1023;
            send_req(op, idx, last, 1'b0, NONE);
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("items left without a result");
      if (err_count == 0)
         $display("bitmap_set_test_clear_range test passed");
      else
         $display("bitmap_set_test_clear_range test failed");
      $finish;
   end

endmodule
